@@ design/wsmf_pkg.sv @@
`timescale 1ns / 1ps
// Shared package for the word substring match filter.
// Holds field widths, register indexes, the result type and the character class function.
package wsmf_pkg;

  localparam int CHAR_W      = 8;
  localparam int LINE_W      = 24;
  localparam int OFFSET_W    = 32;
  localparam int LENGTH_W    = 16;
  localparam int PAT_BYTES_W = 64;
  localparam int PAT_LEN_W   = 4;
  localparam int CFG_INDEX_W = 2;

  // Default pattern capacity in bytes; the design accepts 1 to 8.
  localparam int DEFAULT_MAX_PATTERN = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

  localparam logic [CHAR_W-1:0]   NEWLINE_CHAR = 8'd10;
  localparam logic [LINE_W-1:0]   LINE_FIRST   = 24'd1;
  localparam logic [LINE_W-1:0]   LINE_MAX     = 24'hFF_FFFF;
  localparam logic [LENGTH_W-1:0] LENGTH_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [LINE_W-1:0]   line_number;
    logic [OFFSET_W-1:0] word_offset;
    logic [LENGTH_W-1:0] word_length;
    logic                starts_with;
    logic                contains;
    logic                contains_reversed;
  } wsmf_result_t;

  // True for ASCII digits and letters of either case.
  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    is_alnum = ((c >= 8'd48) && (c <= 8'd57)) ||
               ((c >= 8'd65) && (c <= 8'd90)) ||
               ((c >= 8'd97) && (c <= 8'd122));
  endfunction

endpackage

@@ design/wsmf_match.sv @@
`timescale 1ns / 1ps
// Window comparator: checks the newest window bytes against the pattern and its reverse.
// Depends on wsmf_pkg.
module wsmf_match #(
  parameter int MAX_PATTERN = wsmf_pkg::DEFAULT_MAX_PATTERN
) (
  input  logic [MAX_PATTERN-1:0][wsmf_pkg::CHAR_W-1:0] window,
  input  logic [MAX_PATTERN-1:0][wsmf_pkg::CHAR_W-1:0] pattern,
  input  logic [wsmf_pkg::PAT_LEN_W-1:0]               eff_length,
  output logic                                         forward_hit,
  output logic                                         reverse_hit
);
  import wsmf_pkg::*;

  logic [MAX_PATTERN-1:0] fwd_by_len;
  logic [MAX_PATTERN-1:0] rev_by_len;

  // One comparison per candidate length; window byte 0 is the newest character.
  always_comb begin
    for (int m = 1; m <= MAX_PATTERN; m++) begin
      fwd_by_len[m-1] = 1'b1;
      rev_by_len[m-1] = 1'b1;
      for (int i = 0; i < m; i++) begin
        if (pattern[i] != window[m-1-i]) begin
          fwd_by_len[m-1] = 1'b0;
        end
        if (pattern[i] != window[i]) begin
          rev_by_len[m-1] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    forward_hit = 1'b0;
    reverse_hit = 1'b0;
    for (int m = 1; m <= MAX_PATTERN; m++) begin
      if (eff_length == PAT_LEN_W'(m)) begin
        forward_hit = fwd_by_len[m-1];
        reverse_hit = rev_by_len[m-1];
      end
    end
  end

endmodule

@@ design/wsmf_scan.sv @@
`timescale 1ns / 1ps
// Word scanner: per-word state, line and position counters, and result formation.
// Depends on wsmf_pkg and wsmf_match.
module wsmf_scan #(
  parameter int MAX_PATTERN = wsmf_pkg::DEFAULT_MAX_PATTERN
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         fire,
  input  logic [wsmf_pkg::CHAR_W-1:0]                  char_in,
  input  logic                                         end_of_text,
  input  logic [MAX_PATTERN-1:0][wsmf_pkg::CHAR_W-1:0] pattern,
  input  logic [wsmf_pkg::PAT_LEN_W-1:0]               pattern_length,
  output logic                                         hit,
  output wsmf_pkg::wsmf_result_t                       result
);
  import wsmf_pkg::*;

  logic [MAX_PATTERN-1:0][CHAR_W-1:0] window, window_next, window_shift;
  logic                               in_word, in_word_next;
  logic [LENGTH_W-1:0]                word_length, word_length_next, length_upd;
  logic [OFFSET_W-1:0]                word_start, word_start_next, start_upd;
  logic [OFFSET_W-1:0]                byte_position, byte_position_next;
  logic [LINE_W-1:0]                  current_line, current_line_next;
  logic                               prefix_hit, prefix_hit_next;
  logic                               contains_hit, contains_hit_next;
  logic                               reverse_hit, reverse_hit_next;
  logic                               prefix_upd, contains_upd, reverse_upd;
  logic [PAT_LEN_W-1:0]               eff_length;
  logic                               alnum, fwd_match, rev_match, compare_en;
  logic                               src_in_word, src_prefix, src_contains, src_reverse;

  assign eff_length = (pattern_length > PAT_LEN_W'(MAX_PATTERN)) ?
                      PAT_LEN_W'(MAX_PATTERN) : pattern_length;
  assign alnum = is_alnum(char_in);

  // The window restarts with the first character of a word.
  always_comb begin
    window_shift[0] = char_in;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_shift[k] = in_word ? window[k-1] : '0;
    end
  end

  assign length_upd = !in_word ? LENGTH_W'(1) :
                      (word_length == LENGTH_MAX) ? word_length :
                      word_length + LENGTH_W'(1);
  assign start_upd  = in_word ? word_start : byte_position;

  wsmf_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .window      (window_shift),
    .pattern     (pattern),
    .eff_length  (eff_length),
    .forward_hit (fwd_match),
    .reverse_hit (rev_match)
  );

  // Flags after taking a word character; an empty pattern marks every word.
  always_comb begin
    compare_en   = (eff_length != '0) && (length_upd >= LENGTH_W'(eff_length));
    prefix_upd   = prefix_hit   | (!in_word && (eff_length == '0));
    contains_upd = contains_hit | (!in_word && (eff_length == '0));
    reverse_upd  = reverse_hit  | (!in_word && (eff_length == '0));
    if (compare_en) begin
      contains_upd = contains_upd | fwd_match;
      prefix_upd   = prefix_upd | (fwd_match && (length_upd == LENGTH_W'(eff_length)));
      reverse_upd  = reverse_upd | rev_match;
    end
  end

  // A word closes on a separator, reporting the state as it stood, or at the end of
  // the text after the last character has been taken in.
  always_comb begin
    src_in_word  = alnum ? 1'b1         : in_word;
    src_prefix   = alnum ? prefix_upd   : prefix_hit;
    src_contains = alnum ? contains_upd : contains_hit;
    src_reverse  = alnum ? reverse_upd  : reverse_hit;
    hit = fire && (!alnum || end_of_text) && src_in_word &&
          (src_prefix || src_contains || src_reverse);
    result.line_number       = current_line;
    result.word_offset       = alnum ? start_upd  : word_start;
    result.word_length       = alnum ? length_upd : word_length;
    result.starts_with       = src_prefix;
    result.contains          = src_contains;
    result.contains_reversed = src_reverse;
  end

  always_comb begin
    window_next        = window;
    in_word_next       = in_word;
    word_length_next   = word_length;
    word_start_next    = word_start;
    current_line_next  = current_line;
    prefix_hit_next    = prefix_hit;
    contains_hit_next  = contains_hit;
    reverse_hit_next   = reverse_hit;
    byte_position_next = byte_position + OFFSET_W'(1);
    if (alnum) begin
      window_next       = window_shift;
      in_word_next      = 1'b1;
      word_length_next  = length_upd;
      word_start_next   = start_upd;
      prefix_hit_next   = prefix_upd;
      contains_hit_next = contains_upd;
      reverse_hit_next  = reverse_upd;
    end else begin
      window_next       = '0;
      in_word_next      = 1'b0;
      word_length_next  = '0;
      prefix_hit_next   = 1'b0;
      contains_hit_next = 1'b0;
      reverse_hit_next  = 1'b0;
      if ((char_in == NEWLINE_CHAR) && (current_line != LINE_MAX)) begin
        current_line_next = current_line + LINE_W'(1);
      end
    end
    if (end_of_text) begin
      window_next        = '0;
      in_word_next       = 1'b0;
      word_length_next   = '0;
      word_start_next    = '0;
      byte_position_next = '0;
      current_line_next  = LINE_FIRST;
      prefix_hit_next    = 1'b0;
      contains_hit_next  = 1'b0;
      reverse_hit_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      in_word       <= 1'b0;
      word_length   <= '0;
      word_start    <= '0;
      byte_position <= '0;
      current_line  <= LINE_FIRST;
      prefix_hit    <= 1'b0;
      contains_hit  <= 1'b0;
      reverse_hit   <= 1'b0;
    end else if (fire) begin
      window        <= window_next;
      in_word       <= in_word_next;
      word_length   <= word_length_next;
      word_start    <= word_start_next;
      byte_position <= byte_position_next;
      current_line  <= current_line_next;
      prefix_hit    <= prefix_hit_next;
      contains_hit  <= contains_hit_next;
      reverse_hit   <= reverse_hit_next;
    end
  end

endmodule

@@ design/word_substring_match_filter_top.sv @@
`timescale 1ns / 1ps
// Top level of the word substring match filter: input register, configuration
// registers and result register around the scanner. Depends on wsmf_pkg and wsmf_scan.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+---------------------------------------
//  text     | in        | text_valid/stall     | char_in, end_of_text
//  match    | out       | match_valid/stall    | line_number .. contains_reversed
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A text byte is transferred into the input register and scanned from there; any word
// report is loaded into the result register, from which the match transfer is made.
// One byte per cycle while the text channel does not stall.
// Reset (rst, synchronous, active high) empties both registers, clears word state and
// pattern, and sets the line count to one. The text channel stalls only while the input
// register is full and a waiting result cannot leave the result register.
module word_substring_match_filter_top #(
  parameter int MAX_PATTERN = wsmf_pkg::DEFAULT_MAX_PATTERN
) (
  input  logic                               clk,
  input  logic                               rst,

  input  logic                               text_valid,
  output logic                               text_stall,
  input  logic [wsmf_pkg::CHAR_W-1:0]        char_in,
  input  logic                               end_of_text,

  output logic                               match_valid,
  input  logic                               match_stall,
  output logic [wsmf_pkg::LINE_W-1:0]        line_number,
  output logic [wsmf_pkg::OFFSET_W-1:0]      word_offset,
  output logic [wsmf_pkg::LENGTH_W-1:0]      word_length,
  output logic                               starts_with,
  output logic                               contains,
  output logic                               contains_reversed,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsmf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wsmf_pkg::PAT_BYTES_W-1:0]   cfg_data
);
  import wsmf_pkg::*;

  // Configuration registers. Only the bytes the pattern can use are kept.
  logic [MAX_PATTERN-1:0][CHAR_W-1:0] pattern;
  logic [PAT_LEN_W-1:0]               pattern_length;

  // Input register.
  logic              in_valid, in_valid_next;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  // Result register.
  logic         res_valid, res_valid_next;
  wsmf_result_t res_data;

  logic         text_take, advance, fire, scan_hit;
  wsmf_result_t scan_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_BYTES: begin
          pattern <= cfg_data[CHAR_W*MAX_PATTERN-1:0];
        end
        REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[PAT_LEN_W-1:0];
        end
        default: begin
          // Writes to indexes beyond the register list are dropped.
        end
      endcase
    end
  end

  // The scanner may run whenever the result register is free or being emptied this
  // cycle, so a waiting result never blocks the byte behind it for longer than needed.
  assign advance    = !res_valid || !match_stall;
  assign fire       = in_valid && advance;
  assign text_stall = in_valid && !advance;
  assign text_take  = text_valid && !text_stall;

  always_comb begin
    in_valid_next = in_valid;
    if (text_take) begin
      in_valid_next = 1'b1;
    end else if (fire) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      in_char <= char_in;
      in_last <= end_of_text;
    end
  end

  wsmf_scan #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .char_in        (in_char),
    .end_of_text    (in_last),
    .pattern        (pattern),
    .pattern_length (pattern_length),
    .hit            (scan_hit),
    .result         (scan_result)
  );

  // A result is loaded only when the scanner ran, which already implies the register
  // is free or its contents are leaving in the same cycle.
  always_comb begin
    res_valid_next = res_valid;
    if (scan_hit) begin
      res_valid_next = 1'b1;
    end else if (!match_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_hit) begin
      res_data <= scan_result;
    end
  end

  assign match_valid       = res_valid;
  assign line_number       = res_data.line_number;
  assign word_offset       = res_data.word_offset;
  assign word_length       = res_data.word_length;
  assign starts_with       = res_data.starts_with;
  assign contains          = res_data.contains;
  assign contains_reversed = res_data.contains_reversed;

`ifndef ASSERT_OFF
  // A reported word always carries at least one flag.
  a_result_flagged: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.starts_with || res_data.contains || res_data.contains_reversed))
    else $error("result without any match flag");

  // A reported word is never empty and its line count never drops to zero.
  a_result_sane: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_data.word_length != '0) && (res_data.line_number != '0)))
    else $error("result with zero length or zero line");

  // The scanner only produces a result when it has a byte and room to deliver.
  a_hit_has_room: assert property (@(posedge clk) disable iff (rst)
    scan_hit |-> (in_valid && (!res_valid || !match_stall)))
    else $error("result produced without a byte or without room");

  // A stalled byte stays in the input register until the scanner takes it.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input byte lost while stalled");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for word_substring_match_filter_top: a directed script, then random text.
// Holds its own word scanner to predict word reports. Depends on wsmf_pkg and the design.
module tb;
  import wsmf_pkg::*;

  // Generous cap on the run: all the transfers, each of which may wait out a sender gap
  // and a stalled receiver, need far fewer cycles than this.
  localparam int LIMIT_CYCLES    = 200_000;
  // A byte passes the input and result registers; this wait lets the design empty out.
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 100;
  // A word much longer than the window, so only its newest bytes can match.
  localparam int LONG_WORD       = 40;

  // Phases with a special role in the random part.
  localparam int FREE_PHASE      = 0;
  localparam int FULL_LEN_PHASE  = 1;
  localparam int PRESSURE_PHASE  = 2;
  localparam int ALL_ONES_PHASE  = 3;
  localparam int PAUSE_PHASE     = 5;
  localparam int EMPTY_PHASE     = 6;

  // Register indexes beyond the list; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {ROW_TEXT, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {FROM_MODEL, NO_REPORT, TYPED_REPORT} report_src_t;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  // One line of the directed script: either a text byte or a register write.
  typedef struct packed {
    row_kind_t                 kind;
    report_src_t               src;
    logic [CFG_INDEX_W-1:0]    reg_index;
    logic [PAT_BYTES_W-1:0]    value;
    logic                      last;
    wsmf_result_t              report;
  } stim_row_t;

  // Every input is given a known value from time zero.
  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    text_valid  = 1'b0;
  logic                    text_stall;
  logic [CHAR_W-1:0]       char_in     = '0;
  logic                    end_of_text = 1'b0;
  logic                    match_valid;
  logic                    match_stall = 1'b0;
  logic [LINE_W-1:0]       line_number;
  logic [OFFSET_W-1:0]     word_offset;
  logic [LENGTH_W-1:0]     word_length;
  logic                    starts_with;
  logic                    contains;
  logic                    contains_reversed;
  logic                    cfg_valid   = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index   = '0;
  logic [PAT_BYTES_W-1:0]  cfg_data    = '0;

  word_substring_match_filter_top dut (.*);

  always #5 clk = ~clk;

  // Scanner state as this testbench sees it. The declared values are the reset values;
  // reset is applied only once, at the start of the run.
  logic [PAT_BYTES_W-1:0]  pattern_reg     = '0;
  logic [PAT_LEN_W-1:0]    pattern_len_reg = '0;
  logic [63:0]             win             = '0;
  logic                    word_open       = 1'b0;
  logic [LENGTH_W-1:0]     word_len        = '0;
  logic [OFFSET_W-1:0]     word_start      = '0;
  logic [OFFSET_W-1:0]     text_pos        = '0;
  logic [LINE_W-1:0]       text_line       = LINE_FIRST;
  logic                    hit_prefix      = 1'b0;
  logic                    hit_contains    = 1'b0;
  logic                    hit_reverse     = 1'b0;

  // Word reports still to come out of the design, oldest first.
  wsmf_result_t pending_reports[$];
  int           mismatches   = 0;
  int           items_sent   = 0;
  bit           gaps_enabled = 1'b1;
  int           burst_left   = 0;
  bit           hold_request = 1'b0;

  function automatic logic word_char(input logic [CHAR_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Pattern lengths above eight behave as eight.
  function automatic int pattern_span();
    return (pattern_len_reg > 4'd8) ? 8 : int'(pattern_len_reg);
  endfunction

  function automatic wsmf_result_t report(input int unsigned line, input int unsigned offset,
                                          input int unsigned len, input logic [2:0] flags);
    wsmf_result_t r;
    r.line_number = LINE_W'(line);
    r.word_offset = offset;
    r.word_length = LENGTH_W'(len);
    {r.starts_with, r.contains, r.contains_reversed} = flags;
    return r;
  endfunction

  // Ends the open word: a report comes out only if one of its flags is set.
  task automatic close_word(output logic got, output wsmf_result_t rep);
    got = word_open && (hit_prefix || hit_contains || hit_reverse);
    rep.line_number       = text_line;
    rep.word_offset       = word_start;
    rep.word_length       = word_len;
    rep.starts_with       = hit_prefix;
    rep.contains          = hit_contains;
    rep.contains_reversed = hit_reverse;
    win          = '0;
    word_open    = 1'b0;
    word_len     = '0;
    hit_prefix   = 1'b0;
    hit_contains = 1'b0;
    hit_reverse  = 1'b0;
  endtask

  // Advances the scanner by one text byte and says whether a word report results.
  task automatic scan_byte(input logic [CHAR_W-1:0] c, input logic last,
                           output logic got, output wsmf_result_t rep);
    int   n;
    int   i;
    logic fwd;
    logic bwd;
    got = 1'b0;
    rep = '0;
    n   = pattern_span();
    if (word_char(c)) begin
      if (!word_open) begin
        word_open  = 1'b1;
        word_start = text_pos;
        word_len   = '0;
        win        = '0;
        // An empty pattern is found in every word.
        if (n == 0) begin
          hit_prefix   = 1'b1;
          hit_contains = 1'b1;
          hit_reverse  = 1'b1;
        end
      end
      win = {win[55:0], c};
      if (word_len != LENGTH_MAX) word_len++;
      if (n != 0 && word_len >= n) begin
        // The newest byte sits lowest in the window, so the pattern read forwards lines up
        // with the window read from the top of the last n bytes, and the reversed pattern
        // lines up byte for byte.
        fwd = 1'b1;
        bwd = 1'b1;
        for (i = 0; i < n; i++) begin
          if (pattern_reg[8*i +: 8] != win[8*(n-1-i) +: 8]) fwd = 1'b0;
          if (pattern_reg[8*i +: 8] != win[8*i +: 8]) bwd = 1'b0;
        end
        if (fwd) begin
          hit_contains = 1'b1;
          if (word_len == n) hit_prefix = 1'b1;
        end
        if (bwd) hit_reverse = 1'b1;
      end
    end else begin
      close_word(got, rep);
      if (c == NEWLINE_CHAR && text_line != LINE_MAX) text_line++;
    end
    text_pos++;
    // End of text flushes any open word and returns the counters to their start values.
    if (last) begin
      if (!got) close_word(got, rep);
      word_start = '0;
      text_pos   = '0;
      text_line  = LINE_FIRST;
    end
  endtask

  // With gaps on, the sender works in bursts and drops valid for a while after each burst.
  task automatic pace_sender();
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        text_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Offers one text byte, holds it until the transfer, then records what it should cause.
  task automatic send_text(input logic [CHAR_W-1:0] c, input logic last,
                           input report_src_t src = FROM_MODEL,
                           input wsmf_result_t typed = '0);
    logic         got;
    wsmf_result_t rep;
    char_in     <= c;
    end_of_text <= last;
    text_valid  <= 1'b1;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    scan_byte(c, last, got, rep);
    if (src == TYPED_REPORT) pending_reports = {pending_reports, typed};
    else if (src == FROM_MODEL && got) pending_reports = {pending_reports, rep};
    items_sent++;
    pace_sender();
  endtask

  // Stops offering text and waits until every report has arrived and the pipeline is empty.
  task automatic wait_idle();
    text_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [PAT_BYTES_W-1:0] val);
    wait_idle();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_PATTERN_BYTES) pattern_reg = val;
    else if (idx == REG_PATTERN_LENGTH) pattern_len_reg = val[PAT_LEN_W-1:0];
  endtask

  function automatic stim_row_t text_row(input logic [CHAR_W-1:0] c, input logic last,
                                         input report_src_t src = FROM_MODEL,
                                         input wsmf_result_t rep = '0);
    stim_row_t r;
    r        = '0;
    r.kind   = ROW_TEXT;
    r.src    = src;
    r.value  = PAT_BYTES_W'(c);
    r.last   = last;
    r.report = rep;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [PAT_BYTES_W-1:0] val);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_REG;
    r.reg_index = idx;
    r.value     = val;
    return r;
  endfunction

  // Word characters: mostly a small alphabet, so that patterns built from it turn up often.
  function automatic logic [CHAR_W-1:0] pick_char(input bit wide);
    logic [CHAR_W-1:0] c;
    if (wide) begin
      do c = CHAR_W'($urandom_range(0, 255)); while (!word_char(c));
    end else begin
      case ($urandom_range(0, 4))
        0:       c = "a";
        1:       c = "b";
        2:       c = "c";
        3:       c = "A";
        default: c = "1";
      endcase
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_separator();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(0, 5))
      0, 1:    c = " ";
      2, 3:    c = NEWLINE_CHAR;
      default: do c = CHAR_W'($urandom_range(0, 255)); while (word_char(c));
    endcase
    return c;
  endfunction

  // Chooses a pattern for a phase and writes both registers in either order. Some phases force
  // the extremes: a full-length pattern, a pattern of all-ones bytes and an empty pattern.
  task automatic pick_pattern(input int ph);
    logic [PAT_BYTES_W-1:0] bytes;
    logic [PAT_BYTES_W-1:0] len_word;
    int                     i;
    for (i = 0; i < 8; i++) bytes[8*i +: 8] = pick_char($urandom_range(0, 5) == 0);
    if (ph == ALL_ONES_PHASE) bytes = '1;
    else if ($urandom_range(0, 9) == 0) bytes = '0;
    // The upper bits of a length write are random; only the low four bits count.
    len_word = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       len_word[3:0] = 4'd0;
      1:       len_word[3:0] = 4'd8;
      2:       len_word[3:0] = PAT_LEN_W'($urandom_range(9, 15));
      3:       len_word[3:0] = PAT_LEN_W'($urandom_range(4, 7));
      default: len_word[3:0] = PAT_LEN_W'($urandom_range(1, 3));
    endcase
    if (ph == FULL_LEN_PHASE || ph == ALL_ONES_PHASE) len_word[3:0] = 4'd8;
    if (ph == EMPTY_PHASE) len_word[3:0] = 4'd0;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_PATTERN_BYTES, bytes);
      write_reg(REG_PATTERN_LENGTH, len_word);
    end else begin
      write_reg(REG_PATTERN_LENGTH, len_word);
      write_reg(REG_PATTERN_BYTES, bytes);
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
  endtask

  // A word made of pieces: the pattern forwards, the pattern backwards, or single characters.
  task automatic send_word();
    int n;
    int i;
    n = pattern_span();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 5))
        0:       for (i = 0; i < n; i++) send_text(pattern_reg[8*i +: 8], 1'b0);
        1:       for (i = n - 1; i >= 0; i--) send_text(pattern_reg[8*i +: 8], 1'b0);
        2:       send_text(pick_char(1'b1), 1'b0);
        default: send_text(pick_char(1'b0), 1'b0);
      endcase
    end
  endtask

  // Result checker. Inputs are driven with nonblocking assignments, so the values read here
  // just after the edge are the ones that decided the transfer at that edge.
  task automatic log_mismatch(input string why, input wsmf_result_t want,
                              input wsmf_result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s", $realtime, why);
      $display("  expected line %0d offset %0d length %0d flags %b%b%b", want.line_number,
               want.word_offset, want.word_length, want.starts_with, want.contains,
               want.contains_reversed);
      $display("  actual   line %0d offset %0d length %0d flags %b%b%b", seen.line_number,
               seen.word_offset, seen.word_length, seen.starts_with, seen.contains,
               seen.contains_reversed);
    end
  endtask

  always @(posedge clk) begin
    wsmf_result_t seen;
    wsmf_result_t want;
    if (!rst && match_valid && !match_stall) begin
      seen.line_number       = line_number;
      seen.word_offset       = word_offset;
      seen.word_length       = word_length;
      seen.starts_with       = starts_with;
      seen.contains          = contains;
      seen.contains_reversed = contains_reversed;
      if (pending_reports.size() == 0) begin
        log_mismatch("report with none expected", '0, seen);
      end else begin
        want = pending_reports.pop_front();
        if (seen.line_number !== want.line_number || seen.word_offset !== want.word_offset ||
            seen.word_length !== want.word_length || seen.starts_with !== want.starts_with ||
            seen.contains !== want.contains ||
            seen.contains_reversed !== want.contains_reversed)
          log_mismatch("wrong field in report", want, seen);
      end
    end
  end

  // Receiver. It stalls on a pattern of its own that it picks anew at random times, from
  // no stalls at all to stalling most of the time. When asked, it holds off for a long
  // stretch so that the design fills up and has to stall its text input.
  int       hold_left = 0;
  int       mode_left = 0;
  bit       hold_done = 1'b0;
  rx_mode_t rx_mode   = RX_FREE;

  always @(posedge clk) begin
    if (rst) begin
      match_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      match_stall <= 1'b1;
    end else if (hold_request && !hold_done) begin
      hold_done    = 1'b1;
      hold_left    = HOLD_OFF_CYCLES - 1;
      match_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  match_stall <= 1'b0;
        RX_LIGHT: match_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: match_stall <= ($urandom_range(0, 3) != 0);
        default:  match_stall <= ~match_stall;
      endcase
    end
  end

  // Watchdog: a hung handshake or a missing report ends the run here.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    stim_row_t script[$];
    int        ph;
    int        phase_end;
    bit        paused;
    int        i;

    // Directed script. After reset the pattern is empty, so every word is reported with all
    // three flags; those reports are simple enough to be written out by hand.
    script = {script, text_row("A", 1'b0, NO_REPORT)};
    script = {script, text_row(" ", 1'b0, TYPED_REPORT, report(1, 0, 1, 3'b111))};
    script = {script, text_row(NEWLINE_CHAR, 1'b0, NO_REPORT)};
    script = {script, text_row("0", 1'b0, NO_REPORT)};
    script = {script, text_row("9", 1'b0, NO_REPORT)};
    // A byte above the ASCII range ends a word just like any other separator.
    script = {script, text_row(8'hFF, 1'b0, TYPED_REPORT, report(2, 3, 2, 3'b111))};
    // End of text with a word open flushes it, then the counters start over.
    script = {script, text_row("z", 1'b1, TYPED_REPORT, report(2, 6, 1, 3'b111))};
    script = {script, text_row(8'h00, 1'b0, NO_REPORT)};
    script = {script, text_row("{", 1'b1, NO_REPORT)};
    // Pattern "ab". The length write carries ones in every upper bit, which must be dropped.
    script = {script, reg_row(REG_PATTERN_BYTES, 64'h0000_0000_0000_6261)};
    script = {script, reg_row(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF2)};
    script = {script, text_row("a", 1'b0)};
    script = {script, text_row("b", 1'b0)};
    script = {script, text_row("b", 1'b0)};
    script = {script, text_row("a", 1'b0)};
    script = {script, text_row("@", 1'b0)};
    // A word left open across a pattern change keeps the flag it already has.
    script = {script, text_row("b", 1'b0)};
    script = {script, text_row("a", 1'b0)};
    // Length fifteen behaves as eight; pattern "ABCDEFGH". Spare indexes are ignored.
    script = {script, reg_row(REG_PATTERN_LENGTH, 64'h0000_0000_0000_000F)};
    script = {script, reg_row(REG_PATTERN_BYTES, 64'h4847_4645_4443_4241)};
    script = {script, reg_row(REG_SPARE_LO, '1)};
    script = {script, reg_row(REG_SPARE_HI, '1)};
    script = {script, text_row(":", 1'b0)};
    script = {script, text_row("A", 1'b0)};
    script = {script, text_row("B", 1'b0)};
    script = {script, text_row("C", 1'b0)};
    script = {script, text_row("D", 1'b0)};
    script = {script, text_row("E", 1'b0)};
    script = {script, text_row("F", 1'b0)};
    script = {script, text_row("G", 1'b0)};
    script = {script, text_row("H", 1'b1)};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG)
        write_reg(script[i].reg_index, script[i].value);
      else
        send_text(script[i].value[CHAR_W-1:0], script[i].last, script[i].src,
                  script[i].report);
    end

    // Random part: each phase picks a pattern, then sends mostly words built around it,
    // separated by spaces, newlines and other bytes, with some plain noise mixed in.
    for (ph = 0; ph < PHASES; ph++) begin
      pick_pattern(ph);
      gaps_enabled = (ph != FREE_PHASE) && (ph != PRESSURE_PHASE);
      if (ph == PRESSURE_PHASE) hold_request = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      paused    = 1'b0;
      while (items_sent < phase_end) begin
        // Once, halfway through the pause phase, the sender waits for every report to come back.
        if (ph == PAUSE_PHASE && !paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_text(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
        end else begin
          send_word();
          if ($urandom_range(0, 19) == 0) send_text(pick_char(1'b0), 1'b1);
          else send_text(pick_separator(), $urandom_range(0, 24) == 0);
        end
      end
    end

    // One word far longer than the window.
    gaps_enabled = 1'b1;
    for (i = 0; i < LONG_WORD; i++) send_text(pick_char(1'b0), 1'b0);
    send_text(" ", 1'b0);

    wait_idle();
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/wsmf_pkg.sv
design/wsmf_match.sv
design/wsmf_scan.sv
design/word_substring_match_filter_top.sv
tb/tb.sv
